@@ rtl/core/colp_pkg.sv @@
`timescale 1ns / 1ps
// Package for the cascaded one-pole lowpass: microcode types, the control store
// and fixed-point constants. It depends on nothing else.
package colp_pkg;

	localparam int unsigned PC_W = 3;

	localparam logic [1:0] REG_FILTER_ORDER   = 2'd0;
	localparam logic [1:0] REG_BASE_CUTOFF    = 2'd1;
	localparam logic [1:0] REG_RADIANS_PER_HZ = 2'd2;

	localparam logic [1:0]  ORDER_RESET   = 2'd2;
	localparam logic [23:0] CUTOFF_RESET  = 24'd256000;
	localparam logic [31:0] RAD_HZ_RESET  = 32'd562214;

	localparam logic [1:0] ORDER_ONE_POLE = 2'd0;
	localparam logic [1:0] ORDER_TWO_POLE = 2'd1;

	localparam logic [30:0] ALPHA_UNITY = 31'h4000_0000;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_ACCEPT,
		OP_MUL_FREQ,
		OP_MUL_ALPHA,
		OP_SET_ALPHA,
		OP_MUL_STAGE,
		OP_UPD_STAGE,
		OP_OUT
	} op_t;

	typedef enum logic [2:0] {
		COND_NONE,
		COND_IN,
		COND_LOOP,
		COND_OUT,
		COND_JUMP
	} cond_t;

	typedef struct packed {
		op_t              op;
		cond_t            cond;
		logic [PC_W-1:0]  tgt;
	} ctl_t;

	localparam logic [PC_W-1:0] STEP_WAIT      = 3'd0;
	localparam logic [PC_W-1:0] STEP_MUL_STAGE = 3'd4;

	function automatic ctl_t ucode_rom(input logic [PC_W-1:0] pc);
		ctl_t w;
		w = '{op: OP_NOP, cond: COND_JUMP, tgt: STEP_WAIT};
		case (pc)
			3'd0: w = '{op: OP_ACCEPT,    cond: COND_IN,   tgt: STEP_WAIT};
			3'd1: w = '{op: OP_MUL_FREQ,  cond: COND_NONE, tgt: STEP_WAIT};
			3'd2: w = '{op: OP_MUL_ALPHA, cond: COND_NONE, tgt: STEP_WAIT};
			3'd3: w = '{op: OP_SET_ALPHA, cond: COND_NONE, tgt: STEP_WAIT};
			3'd4: w = '{op: OP_MUL_STAGE, cond: COND_NONE, tgt: STEP_WAIT};
			3'd5: w = '{op: OP_UPD_STAGE, cond: COND_LOOP, tgt: STEP_MUL_STAGE};
			3'd6: w = '{op: OP_OUT,       cond: COND_OUT,  tgt: STEP_WAIT};
			default: w = '{op: OP_NOP,    cond: COND_JUMP, tgt: STEP_WAIT};
		endcase
		return w;
	endfunction

endpackage

@@ rtl/core/cascaded_one_pole_lowpass.sv @@
`timescale 1ns / 1ps
// Cascaded one-pole lowpass filter (one, two or four poles) run by a microcoded
// sequencer over one shared multiplier. Depends on colp_pkg.
//
// Usage: an input transfer (in_valid high, in_stall low) carries one sample, its
// pitch ratio and a cutoff offset. The block then computes the coefficient alpha
// and runs each active pole through the shared multiplier, two steps per pole.
// One result transfer follows each input transfer on the output channel.
// The next input is taken in the cycle after the result is loaded into the
// output register, so the block takes no new sample while it still works on
// one; the single multiplier makes the steps of the microprogram run one after
// another. The result sits in an output register; the block takes a new input
// while it waits. If the receiver still stalls when the next result is ready,
// the sequencer holds at its output step and in_stall stays high.
// Configuration writes use cfg_valid/cfg_ready (always ready). The user must
// make them only while the block is idle; the block itself does not enforce
// it. Reset restores the register defaults (four poles, 1000 Hz base cutoff,
// 48 kHz rate factor) and clears all pole states.
module cascaded_one_pole_lowpass import colp_pkg::*; #(
	parameter int unsigned STAGES = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [23:0] sample_in,
	input  logic        [23:0] pitch_ratio,
	input  logic signed [24:0] cutoff_offset,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [23:0] sample_out,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic        [1:0]  cfg_index,
	input  logic        [31:0] cfg_data
);

	localparam int unsigned SW = (STAGES > 1) ? $clog2(STAGES) : 1;
	localparam logic [SW-1:0] LAST_ALL = SW'(STAGES - 1);
	localparam logic [SW-1:0] LAST_TWO = (STAGES > 1) ? SW'(1) : SW'(0);

	logic [PC_W-1:0]    pc_q;
	logic [PC_W-1:0]    pc_nxt;
	ctl_t               ctl;
	logic [1:0]         order_q;
	logic [23:0]        base_q;
	logic [31:0]        rad_q;
	logic signed [23:0] stage_q [STAGES];
	logic [SW-1:0]      stg_q;
	logic [SW-1:0]      last_stg;
	logic signed [23:0] x_q;
	logic [24:0]        eff_q;
	logic [23:0]        pitch_q;
	logic [30:0]        alpha_q;
	logic signed [65:0] prod_q;
	logic signed [23:0] sample_out_q;
	logic               out_valid_q;
	logic               out_free;
	logic signed [25:0] eff_sum;
	logic [31:0]        freq_sat;
	logic signed [24:0] diff;
	logic signed [26:0] upd_sum;
	logic signed [23:0] upd_sat;
	logic signed [32:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [65:0] mul_p;

	assign ctl       = ucode_rom(pc_q);
	assign in_stall  = (ctl.op != OP_ACCEPT);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign sample_out = sample_out_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		case (order_q)
			ORDER_ONE_POLE: last_stg = '0;
			ORDER_TWO_POLE: last_stg = LAST_TWO;
			default:        last_stg = LAST_ALL;
		endcase
	end

	always_comb begin
		case (ctl.cond)
			COND_NONE: pc_nxt = pc_q + 1'b1;
			COND_IN:   pc_nxt = in_valid ? pc_q + 1'b1 : pc_q;
			COND_LOOP: pc_nxt = (stg_q == last_stg) ? pc_q + 1'b1 : ctl.tgt;
			COND_OUT:  pc_nxt = out_free ? ctl.tgt : pc_q;
			COND_JUMP: pc_nxt = ctl.tgt;
			default:   pc_nxt = STEP_WAIT;
		endcase
	end

	assign eff_sum  = $signed({2'b00, base_q}) + 26'(cutoff_offset);
	assign freq_sat = prod_q[48] ? 32'hFFFF_FFFF : prod_q[47:16];
	assign diff     = 25'(x_q) - 25'(stage_q[stg_q]);
	assign upd_sum  = 27'(stage_q[stg_q]) + 27'($signed(prod_q[55:30]));

	always_comb begin
		if (upd_sum > 27'sd8388607) begin
			upd_sat = 24'sh7FFFFF;
		end else if (upd_sum < -27'sd8388608) begin
			upd_sat = 24'sh800000;
		end else begin
			upd_sat = upd_sum[23:0];
		end
	end

	always_comb begin
		case (ctl.op)
			OP_MUL_FREQ: begin
				mul_a = $signed({8'd0, eff_q});
				mul_b = $signed({9'd0, pitch_q});
			end
			OP_MUL_ALPHA: begin
				mul_a = $signed({1'b0, freq_sat});
				mul_b = $signed({1'b0, rad_q});
			end
			OP_MUL_STAGE: begin
				mul_a = 33'(diff);
				mul_b = $signed({2'b00, alpha_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= STEP_WAIT;
			order_q     <= ORDER_RESET;
			base_q      <= CUTOFF_RESET;
			rad_q       <= RAD_HZ_RESET;
			stg_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < STAGES; i++) begin
				stage_q[i] <= '0;
			end
		end else begin
			pc_q <= pc_nxt;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FILTER_ORDER:   order_q <= cfg_data[1:0];
					REG_BASE_CUTOFF:    base_q  <= cfg_data[23:0];
					REG_RADIANS_PER_HZ: rad_q   <= cfg_data;
					default: ;
				endcase
			end
			if (ctl.op == OP_SET_ALPHA) begin
				stg_q <= '0;
			end else if (ctl.op == OP_UPD_STAGE) begin
				stage_q[stg_q] <= upd_sat;
				stg_q <= (stg_q == last_stg) ? '0 : stg_q + 1'b1;
			end
			if (ctl.op == OP_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_ACCEPT: begin
				if (in_valid) begin
					x_q     <= sample_in;
					pitch_q <= pitch_ratio;
					eff_q   <= eff_sum[25] ? 25'd0 : eff_sum[24:0];
				end
			end
			OP_MUL_FREQ, OP_MUL_ALPHA, OP_MUL_STAGE: prod_q <= mul_p;
			OP_SET_ALPHA: begin
				if ((|prod_q[63:41]) || (prod_q[40] && (|prod_q[39:10]))) begin
					alpha_q <= ALPHA_UNITY;
				end else begin
					alpha_q <= prod_q[40:10];
				end
			end
			OP_UPD_STAGE: x_q <= upd_sat;
			OP_OUT: begin
				if (out_free) begin
					sample_out_q <= x_q;
				end
			end
			default: ;
		endcase
	end

endmodule

@@ rtl/core/colp_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for cascaded_one_pole_lowpass and the bind that attaches it.
// Depends only on the top level's port list.
module colp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic signed [23:0] sample_in,
	input logic        [23:0] pitch_ratio,
	input logic signed [24:0] cutoff_offset,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [23:0] sample_out,
	input logic               cfg_valid,
	input logic               cfg_ready,
	input logic        [1:0]  cfg_index,
	input logic        [31:0] cfg_data
);

	// A stalled result stays offered and unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sample_out))
		else $error("stalled result changed");

	// After an input transfer the block is busy computing.
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted while busy");

	// A new result appears only from the busy state.
	a_out_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without work");

	// The configuration port never blocks.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind cascaded_one_pole_lowpass colp_checker u_colp_checker (.*);

@@ dv/cascaded_one_pole_lowpass_checker.sv @@
`timescale 1ns / 1ps
// Checker for the cascaded one-pole lowpass: watches the configuration, input and output
// channels, predicts every filtered sample and compares it with the block's output.
// Depends on colp_pkg for the register indexes, the reset values and the alpha limit.
module cascaded_one_pole_lowpass_checker import colp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic signed [23:0] sample_in,
	input  logic        [23:0] pitch_ratio,
	input  logic signed [24:0] cutoff_offset,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [23:0] sample_out,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic        [1:0]  cfg_index,
	input  logic        [31:0] cfg_data,
	output int                 fail_count,
	output int                 pending_count
);

	localparam int     POLES    = 4;
	localparam longint POLE_MAX = 64'sd8388607;
	localparam longint POLE_MIN = -64'sd8388608;

	logic        [1:0]  order_reg;
	logic        [23:0] cutoff_reg;
	logic        [31:0] rad_reg;
	logic signed [23:0] pole_state [POLES];
	logic signed [23:0] filtered_samples [$];

	function automatic logic signed [23:0] lowpass_sample(
		input logic signed [23:0] smp,
		input logic        [23:0] pitch,
		input logic signed [24:0] cut
	);
		logic signed [25:0] eff;
		logic        [63:0] freq;
		logic        [63:0] alpha;
		longint             x;
		longint             y;
		int                 poles;
		eff = $signed({2'b00, cutoff_reg}) + $signed({cut[24], cut});
		if (eff < 0) begin
			eff = '0;
		end
		freq = (64'(eff[24:0]) * 64'(pitch)) >> 16;
		if (freq > 64'hFFFF_FFFF) begin
			freq = 64'hFFFF_FFFF;
		end
		alpha = (freq * 64'(rad_reg)) >> 10;
		if (alpha > 64'(ALPHA_UNITY)) begin
			alpha = 64'(ALPHA_UNITY);
		end
		case (order_reg)
			ORDER_ONE_POLE: poles = 1;
			ORDER_TWO_POLE: poles = 2;
			default:        poles = POLES;
		endcase
		x = smp;
		for (int i = 0; i < poles; i++) begin
			y = pole_state[i];
			y = y + (((x - y) * longint'(alpha)) >>> 30);
			if (y > POLE_MAX) begin
				y = POLE_MAX;
			end else if (y < POLE_MIN) begin
				y = POLE_MIN;
			end
			pole_state[i] = 24'(y);
			x = y;
		end
		return 24'(x);
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		logic signed [23:0] want;
		int                 errs;
		if (!arst_n) begin
			order_reg  = ORDER_RESET;
			cutoff_reg = CUTOFF_RESET;
			rad_reg    = RAD_HZ_RESET;
			foreach (pole_state[i]) begin
				pole_state[i] = '0;
			end
			filtered_samples.delete();
			fail_count    <= 0;
			pending_count <= 0;
		end else begin
			errs = 0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FILTER_ORDER:   order_reg  = cfg_data[1:0];
					REG_BASE_CUTOFF:    cutoff_reg = cfg_data[23:0];
					REG_RADIANS_PER_HZ: rad_reg    = cfg_data;
					default:            ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (filtered_samples.size() == 0) begin
					$display("%0t: sample_out transfer with nothing pending, expected none, got %0d",
						$time, sample_out);
					errs = 1;
				end else begin
					want = filtered_samples.pop_front();
					if (sample_out !== want) begin
						$display("%0t: sample_out mismatch, expected %0d, got %0d",
							$time, want, sample_out);
						errs = 1;
					end
				end
			end
			if (in_valid && !in_stall) begin
				filtered_samples.push_back(lowpass_sample(sample_in, pitch_ratio, cutoff_offset));
			end
			pending_count <= filtered_samples.size();
			fail_count    <= fail_count + errs;
		end
	end

endmodule

@@ dv/cascaded_one_pole_lowpass_tb.sv @@
`timescale 1ns / 1ps
// Top of the cascaded one-pole lowpass testbench: drives directed and random samples
// through several register settings with random idling on both channels and gives the verdict.
// Depends on colp_pkg, the block and cascaded_one_pole_lowpass_checker.
module cascaded_one_pole_lowpass_tb;
	import colp_pkg::*;

	localparam logic [1:0]         REG_UNUSED       = 2'd3;
	localparam logic [1:0]         ORDER_FOUR_POLE  = 2'd2;
	localparam logic [1:0]         ORDER_UNUSED     = 2'd3;
	localparam logic signed [23:0] SAMPLE_MAX       = 24'h7F_FFFF;
	localparam logic signed [23:0] SAMPLE_MIN       = 24'h80_0000;
	localparam logic        [23:0] PITCH_MAX        = 24'hFF_FFFF;
	localparam logic        [23:0] PITCH_UNITY      = 24'h01_0000;
	localparam logic signed [24:0] OFFSET_MAX       = 25'h0FF_FFFF;
	localparam logic signed [24:0] OFFSET_MIN       = 25'h100_0000;
	localparam int                 MAX_WAIT         = 12;
	localparam int                 PHASES           = 8;
	localparam int                 RANDOM_PER_PHASE = 200;
	localparam int                 SETTLE_CYCLES    = 20;
	localparam int                 CYCLE_LIMIT      = 500000;

	logic               clk           = 1'b0;
	logic               arst_n        = 1'b0;
	logic               in_valid      = 1'b0;
	logic signed [23:0] sample_in     = '0;
	logic        [23:0] pitch_ratio   = '0;
	logic signed [24:0] cutoff_offset = '0;
	logic               out_stall     = 1'b0;
	logic               cfg_valid     = 1'b0;
	logic        [1:0]  cfg_index     = '0;
	logic        [31:0] cfg_data      = '0;
	logic               in_stall;
	logic               out_valid;
	logic signed [23:0] sample_out;
	logic               cfg_ready;
	int                 fail_count;
	int                 pending_count;
	int                 cycles        = 0;
	bit                 in_quiet      = 1'b0;
	bit                 out_quiet     = 1'b0;
	logic signed [23:0] walk_level    = '0;

	always #5 clk = ~clk;

	cascaded_one_pole_lowpass dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample_in    (sample_in),
		.pitch_ratio  (pitch_ratio),
		.cutoff_offset(cutoff_offset),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sample_out   (sample_out),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	cascaded_one_pole_lowpass_checker lowpass_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample_in    (sample_in),
		.pitch_ratio  (pitch_ratio),
		.cutoff_offset(cutoff_offset),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sample_out   (sample_out),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.pending_count(pending_count)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic send_sample(
		input logic signed [23:0] smp,
		input logic        [23:0] pitch,
		input logic signed [24:0] cut
	);
		int gap;
		if ($urandom_range(0, 39) == 0) begin
			in_quiet = !in_quiet;
		end
		gap = in_quiet ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		sample_in     <= smp;
		pitch_ratio   <= pitch;
		cutoff_offset <= cut;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic configure(
		input logic [1:0]  order,
		input logic [23:0] cutoff,
		input logic [31:0] rad,
		input bit          stray
	);
		logic [31:0] junk;
		junk = $urandom;
		if (stray) begin
			write_reg(REG_UNUSED, $urandom);
		end
		write_reg(REG_FILTER_ORDER, {junk[31:2], order});
		write_reg(REG_BASE_CUTOFF, {junk[31:24], cutoff});
		write_reg(REG_RADIANS_PER_HZ, rad);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
	endtask

	task automatic next_random_item(
		output logic signed [23:0] smp,
		output logic        [23:0] pitch,
		output logic signed [24:0] cut
	);
		int pick;
		int step;
		if ($urandom_range(0, 9) < 7) begin
			step = int'($urandom_range(0, 131072)) - 65536;
			walk_level = 24'(int'(walk_level) + step);
		end else begin
			walk_level = 24'($urandom);
		end
		smp = walk_level;
		if ($urandom_range(0, 3) != 0) begin
			pitch = 24'($urandom_range(4096, 1048576));
		end else begin
			pitch = 24'($urandom);
		end
		pick = $urandom_range(0, 9);
		if (pick < 4) begin
			cut = '0;
		end else if (pick < 7) begin
			cut = 25'(int'($urandom_range(0, 262144)) - 131072);
		end else begin
			cut = 25'($urandom);
		end
	endtask

	initial begin : out_side
		int hold;
		forever begin
			if ($urandom_range(0, 39) == 0) begin
				out_quiet = !out_quiet;
			end
			hold = out_quiet ? 0 : $urandom_range(0, MAX_WAIT);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin : in_side
		logic signed [23:0] smp;
		logic        [23:0] pitch;
		logic signed [24:0] cut;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		send_sample('0, PITCH_UNITY, '0);
		send_sample(SAMPLE_MAX, PITCH_UNITY, '0);
		send_sample(SAMPLE_MIN, PITCH_UNITY, '0);
		send_sample(-24'sd1, '0, '0);
		send_sample(SAMPLE_MAX, PITCH_MAX, OFFSET_MAX);
		send_sample(SAMPLE_MIN, PITCH_MAX, OFFSET_MAX);
		send_sample(SAMPLE_MAX, PITCH_MAX, OFFSET_MIN);
		send_sample(24'sd123456, PITCH_UNITY, -25'sd256000);
		send_sample(-24'sd123456, PITCH_UNITY, -25'sd256001);
		send_sample(SAMPLE_MAX, PITCH_MAX, -25'sd1);
		send_sample(24'sd1, 24'd1, 25'sd1);
		send_sample(SAMPLE_MIN, PITCH_UNITY, 25'sd65536);
		send_sample(SAMPLE_MAX, 24'h80_0000, '0);

		for (int p = 0; p < PHASES; p++) begin
			if (p > 0) begin
				drain();
				case (p)
					1: configure(ORDER_ONE_POLE, CUTOFF_RESET, RAD_HZ_RESET, 1'b0);
					2: configure(ORDER_TWO_POLE, 24'hFF_FFFF, 32'hFFFF_FFFF, 1'b1);
					3: configure(ORDER_UNUSED, '0, '0, 1'b0);
					4: configure(ORDER_FOUR_POLE, 24'd1, 32'd1, 1'b1);
					default: configure(2'($urandom_range(0, 3)),
						24'($urandom) >> $urandom_range(0, 8),
						$urandom >> $urandom_range(0, 16), 1'($urandom));
				endcase
			end
			for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
				next_random_item(smp, pitch, cut);
				send_sample(smp, pitch, cut);
			end
		end

		in_valid <= 1'b0;
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
